// File: rtl/swb_pkg.sv
// swb_pkg: shared constants, register map and config struct for the stereo
// width / balance / crossfeed / exciter block. No dependencies.
package swb_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 14;
    localparam int GAIN_FRAC      = 12;
    localparam int GAIN_BITS      = 16;
    localparam int COEF_BITS      = 16;
    localparam int AMT_BITS       = 15;

    // datapath widths, stage by stage
    localparam int W_G1   = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC;
    localparam int W_G2   = W_G1 + GAIN_BITS - GAIN_FRAC;
    localparam int W_SIDE = W_G2 + COEF_BITS - COEF_FRAC_BITS;
    localparam int W_L3   = W_SIDE + 1;
    localparam int W_L4   = W_L3 + 1;
    localparam int W_P    = W_L4 + COEF_BITS - COEF_FRAC_BITS;
    localparam int W_L5   = W_P + 1;
    localparam int W_L6   = W_L5 + AMT_BITS - COEF_FRAC_BITS + 1;
    localparam int W_TERM = SAMPLE_BITS + AMT_BITS - COEF_FRAC_BITS;
    localparam int W_Y    = W_TERM + 1;
    localparam int W_FAC  = COEF_BITS + 1;

    localparam int GAIN_RND   = 1 << (GAIN_FRAC - 1);
    localparam int COEF_RND   = 1 << (COEF_FRAC_BITS - 1);
    localparam int COEF_UNITY = 1 << COEF_FRAC_BITS;

    localparam longint S_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint S_MIN = -(longint'(1) << (SAMPLE_BITS - 1));

    localparam int DATA_BITS = 2 * SAMPLE_BITS;
    localparam int ADDR_BITS = 5;
    localparam int APB_BITS  = 32;

    typedef enum logic [2:0] {
        REG_IN_GAIN,
        REG_OUT_GAIN,
        REG_WIDTH,
        REG_BALANCE,
        REG_BLEND,
        REG_XFEED,
        REG_EXCITE
    } t_reg_idx;

    localparam logic [GAIN_BITS-1:0] RST_GAIN  = GAIN_BITS'(1 << GAIN_FRAC);
    localparam logic [COEF_BITS-1:0] RST_WIDTH = COEF_BITS'(COEF_UNITY);

    typedef struct packed {
        logic        [GAIN_BITS-1:0] in_gain;
        logic        [GAIN_BITS-1:0] out_gain;
        logic        [COEF_BITS-1:0] width;
        logic signed [COEF_BITS-1:0] balance;
        logic signed [COEF_BITS-1:0] blend;
        logic        [AMT_BITS-1:0]  xfeed;
        logic        [AMT_BITS-1:0]  excite;
    } t_cfg;

endpackage

// File: rtl/swb_cfg.sv
// swb_cfg: APB register file holding the seven processing controls.
// Depends on swb_pkg.
module swb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [swb_pkg::ADDR_BITS-1:0]  i_paddr,
    input  logic [swb_pkg::APB_BITS-1:0]   i_pwdata,
    output logic [swb_pkg::APB_BITS-1:0]   o_prdata,
    output swb_pkg::t_cfg                  o_cfg
);
    import swb_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[ADDR_BITS-1:2]);
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_IN_GAIN:  n_cfg.in_gain  = i_pwdata[GAIN_BITS-1:0];
                REG_OUT_GAIN: n_cfg.out_gain = i_pwdata[GAIN_BITS-1:0];
                REG_WIDTH:    n_cfg.width    = i_pwdata[COEF_BITS-1:0];
                REG_BALANCE:  n_cfg.balance  = i_pwdata[COEF_BITS-1:0];
                REG_BLEND:    n_cfg.blend    = i_pwdata[COEF_BITS-1:0];
                REG_XFEED:    n_cfg.xfeed    = i_pwdata[AMT_BITS-1:0];
                REG_EXCITE:   n_cfg.excite   = i_pwdata[AMT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_gain  <= RST_GAIN;
            r_cfg.out_gain <= RST_GAIN;
            r_cfg.width    <= RST_WIDTH;
            r_cfg.balance  <= '0;
            r_cfg.blend    <= '0;
            r_cfg.xfeed    <= '0;
            r_cfg.excite   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_IN_GAIN:  o_prdata = APB_BITS'(r_cfg.in_gain);
            REG_OUT_GAIN: o_prdata = APB_BITS'(r_cfg.out_gain);
            REG_WIDTH:    o_prdata = APB_BITS'(r_cfg.width);
            REG_BALANCE:  o_prdata = APB_BITS'(unsigned'(r_cfg.balance));
            REG_BLEND:    o_prdata = APB_BITS'(unsigned'(r_cfg.blend));
            REG_XFEED:    o_prdata = APB_BITS'(r_cfg.xfeed);
            REG_EXCITE:   o_prdata = APB_BITS'(r_cfg.excite);
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/swb_gain.sv
// swb_gain: two pipeline stages applying input gain, then output gain.
// Depends on swb_pkg.
module swb_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [swb_pkg::SAMPLE_BITS-1:0] i_l,
    input  logic signed [swb_pkg::SAMPLE_BITS-1:0] i_r,
    input  swb_pkg::t_cfg                       i_cfg,
    output logic                                o_valid,
    output logic signed [swb_pkg::W_G2-1:0]     o_l,
    output logic signed [swb_pkg::W_G2-1:0]     o_r
);
    import swb_pkg::*;

    localparam int P1 = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int P2 = W_G1 + GAIN_BITS + 1;

    logic                   r_v1, r_v2;
    logic signed [W_G1-1:0] r_g1_l, r_g1_r;
    logic signed [W_G2-1:0] r_g2_l, r_g2_r;
    logic signed [P1-1:0]   p1_l, p1_r, q1_l, q1_r;
    logic signed [P2-1:0]   p2_l, p2_r, q2_l, q2_r;
    logic signed [W_G1-1:0] n_g1_l, n_g1_r;
    logic signed [W_G2-1:0] n_g2_l, n_g2_r;

    always_comb begin
        p1_l   = i_l * $signed({1'b0, i_cfg.in_gain});
        p1_r   = i_r * $signed({1'b0, i_cfg.in_gain});
        q1_l   = (p1_l + P1'(GAIN_RND)) >>> GAIN_FRAC;
        q1_r   = (p1_r + P1'(GAIN_RND)) >>> GAIN_FRAC;
        n_g1_l = q1_l[W_G1-1:0];
        n_g1_r = q1_r[W_G1-1:0];

        p2_l   = r_g1_l * $signed({1'b0, i_cfg.out_gain});
        p2_r   = r_g1_r * $signed({1'b0, i_cfg.out_gain});
        q2_l   = (p2_l + P2'(GAIN_RND)) >>> GAIN_FRAC;
        q2_r   = (p2_r + P2'(GAIN_RND)) >>> GAIN_FRAC;
        n_g2_l = q2_l[W_G2-1:0];
        n_g2_r = q2_r[W_G2-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1_l <= n_g1_l;
            r_g1_r <= n_g1_r;
            r_g2_l <= n_g2_l;
            r_g2_r <= n_g2_r;
        end
    end

    assign o_valid = r_v2;
    assign o_l     = r_g2_l;
    assign o_r     = r_g2_r;

endmodule

// File: rtl/swb_image.sv
// swb_image: five pipeline stages for width, balance, mid/side blend and
// crossfeed. Depends on swb_pkg.
module swb_image (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [swb_pkg::W_G2-1:0]  i_l,
    input  logic signed [swb_pkg::W_G2-1:0]  i_r,
    input  swb_pkg::t_cfg                    i_cfg,
    output logic                             o_valid,
    output logic signed [swb_pkg::W_L6-1:0]  o_l,
    output logic signed [swb_pkg::W_L6-1:0]  o_r
);
    import swb_pkg::*;

    localparam int PS = W_G2 + COEF_BITS + 1;
    localparam int PB = W_L3 + W_FAC;
    localparam int PP = W_L4 + COEF_BITS;
    localparam int PX = W_L5 + AMT_BITS + 1;

    logic [4:0] r_v;

    // stage 3: width
    logic signed [W_G2:0]     sum3, dif3;
    logic signed [PS-1:0]     ps, qs;
    logic signed [W_G2-1:0]   n_mid3;
    logic signed [W_SIDE-1:0] n_side3;
    logic signed [W_G2-1:0]   r_mid3;
    logic signed [W_SIDE-1:0] r_side3;

    // stage 4: balance
    logic signed [W_L3-1:0]   l3, r3;
    logic signed [W_FAC-1:0]  fac_l, fac_r;
    logic signed [PB-1:0]     pb_l, pb_r, qb_l, qb_r;
    logic signed [W_L4-1:0]   n_l4, n_r4, r_l4, r_r4;

    // stage 5: blend product
    logic signed [W_L4:0]     sum5, dif5;
    logic signed [PP-1:0]     pp, qp;
    logic signed [W_L4-1:0]   n_m5, n_s5, r_m5, r_s5;
    logic signed [W_P-1:0]    n_p5, r_p5;

    // stage 6: rebuild
    logic signed [W_L5-1:0]   n_l6, n_r6, r_l6, r_r6;

    // stage 7: crossfeed
    logic signed [PX-1:0]     px_l, px_r, qx_l, qx_r;
    logic signed [W_L6-1:0]   n_l7, n_r7, r_l7, r_r7;

    always_comb begin
        sum3    = (W_G2 + 1)'(i_l) + (W_G2 + 1)'(i_r);
        dif3    = (W_G2 + 1)'(i_l) - (W_G2 + 1)'(i_r);
        n_mid3  = sum3[W_G2:1];
        ps      = $signed(dif3[W_G2:1]) * $signed({1'b0, i_cfg.width});
        qs      = (ps + PS'(COEF_RND)) >>> COEF_FRAC_BITS;
        n_side3 = qs[W_SIDE-1:0];
    end

    always_comb begin
        l3    = W_L3'(r_mid3) + W_L3'(r_side3);
        r3    = W_L3'(r_mid3) - W_L3'(r_side3);
        fac_l = W_FAC'(COEF_UNITY) - W_FAC'(i_cfg.balance);
        fac_r = W_FAC'(COEF_UNITY) + W_FAC'(i_cfg.balance);
        pb_l  = l3 * fac_l;
        pb_r  = r3 * fac_r;
        qb_l  = (pb_l + PB'(COEF_RND)) >>> COEF_FRAC_BITS;
        qb_r  = (pb_r + PB'(COEF_RND)) >>> COEF_FRAC_BITS;
        // positive balance cuts left, negative cuts right
        n_l4  = (i_cfg.balance > 0) ? qb_l[W_L4-1:0] : W_L4'(l3);
        n_r4  = (i_cfg.balance < 0) ? qb_r[W_L4-1:0] : W_L4'(r3);
    end

    always_comb begin
        sum5 = (W_L4 + 1)'(r_l4) + (W_L4 + 1)'(r_r4);
        dif5 = (W_L4 + 1)'(r_l4) - (W_L4 + 1)'(r_r4);
        n_m5 = sum5[W_L4:1];
        n_s5 = dif5[W_L4:1];
        pp   = n_s5 * i_cfg.blend;
        qp   = (pp + PP'(COEF_RND)) >>> COEF_FRAC_BITS;
        n_p5 = qp[W_P-1:0];
    end

    // l = (mid + p) + (side - p); r = (mid + p) - (side - p)
    always_comb begin
        n_l6 = W_L5'(r_m5) + W_L5'(r_s5);
        n_r6 = W_L5'(r_m5) - W_L5'(r_s5) + (W_L5'(r_p5) <<< 1);
    end

    always_comb begin
        px_l = r_r6 * $signed({1'b0, i_cfg.xfeed});
        px_r = r_l6 * $signed({1'b0, i_cfg.xfeed});
        qx_l = (px_l + PX'(COEF_RND)) >>> COEF_FRAC_BITS;
        qx_r = (px_r + PX'(COEF_RND)) >>> COEF_FRAC_BITS;
        n_l7 = W_L6'(r_l6) + qx_l[W_L6-1:0];
        n_r7 = W_L6'(r_r6) + qx_r[W_L6-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid3  <= n_mid3;
            r_side3 <= n_side3;
            r_l4    <= n_l4;
            r_r4    <= n_r4;
            r_m5    <= n_m5;
            r_s5    <= n_s5;
            r_p5    <= n_p5;
            r_l6    <= n_l6;
            r_r6    <= n_r6;
            r_l7    <= n_l7;
            r_r7    <= n_r7;
        end
    end

    assign o_valid = r_v[4];
    assign o_l     = r_l7;
    assign o_r     = r_r7;

endmodule

// File: rtl/swb_exciter.sv
// swb_exciter: clamp, square, scale and final clamp (two register stages and
// a combinational tail into the output register). Depends on swb_pkg.
module swb_exciter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [swb_pkg::W_L6-1:0]        i_l,
    input  logic signed [swb_pkg::W_L6-1:0]        i_r,
    input  swb_pkg::t_cfg                          i_cfg,
    output logic                                   o_valid,
    output logic signed [swb_pkg::SAMPLE_BITS-1:0] o_l,
    output logic signed [swb_pkg::SAMPLE_BITS-1:0] o_r,
    output logic                                   o_clip
);
    import swb_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int TB = S + AMT_BITS;

    logic r_v8, r_v9;

    // stage 8: first clamp and square
    logic signed [S-1:0]   c_l, c_r;
    logic                  clip8;
    logic [S-1:0]          cu_l, cu_r, mag_l, mag_r;
    logic [2*S-1:0]        n_sq_l, n_sq_r, r_sq_l, r_sq_r;
    logic signed [S-1:0]   r_x8_l, r_x8_r;
    logic                  r_c8;

    // stage 9: rounded square times amount
    logic [2*S:0]          ss_l, ss_r;
    logic [S-1:0]          sq_l, sq_r;
    logic [TB-1:0]         n_t_l, n_t_r, r_t_l, r_t_r;
    logic signed [S-1:0]   r_x9_l, r_x9_r;
    logic                  r_c9;

    // tail: add term, final clamp
    logic [TB:0]           ts_l, ts_r;
    logic [W_TERM-1:0]     term_l, term_r;
    logic signed [W_Y-1:0] y_l, y_r;
    logic                  hi_l, lo_l, hi_r, lo_r;

    always_comb begin
        hi_l  = i_l > W_L6'(S_MAX);
        lo_l  = i_l < W_L6'(S_MIN);
        hi_r  = i_r > W_L6'(S_MAX);
        lo_r  = i_r < W_L6'(S_MIN);
        c_l   = hi_l ? S'(S_MAX) : (lo_l ? S'(S_MIN) : i_l[S-1:0]);
        c_r   = hi_r ? S'(S_MAX) : (lo_r ? S'(S_MIN) : i_r[S-1:0]);
        clip8 = hi_l | lo_l | hi_r | lo_r;
        cu_l  = c_l;
        cu_r  = c_r;
        // the most negative sample maps to 2^(S-1), which still fits unsigned
        mag_l = c_l[S-1] ? (~cu_l + S'(1)) : cu_l;
        mag_r = c_r[S-1] ? (~cu_r + S'(1)) : cu_r;
        n_sq_l = mag_l * mag_l;
        n_sq_r = mag_r * mag_r;
    end

    always_comb begin
        ss_l  = {1'b0, r_sq_l} + (2*S + 1)'(longint'(1) << (S - 2));
        ss_r  = {1'b0, r_sq_r} + (2*S + 1)'(longint'(1) << (S - 2));
        sq_l  = ss_l[2*S-2:S-1];
        sq_r  = ss_r[2*S-2:S-1];
        n_t_l = sq_l * i_cfg.excite;
        n_t_r = sq_r * i_cfg.excite;
    end

    always_comb begin
        ts_l   = {1'b0, r_t_l} + (TB + 1)'(COEF_RND);
        ts_r   = {1'b0, r_t_r} + (TB + 1)'(COEF_RND);
        term_l = ts_l[TB-1:COEF_FRAC_BITS];
        term_r = ts_r[TB-1:COEF_FRAC_BITS];
        y_l    = W_Y'(r_x9_l) + $signed({1'b0, term_l});
        y_r    = W_Y'(r_x9_r) + $signed({1'b0, term_r});
        o_l    = (y_l > W_Y'(S_MAX)) ? S'(S_MAX) :
                 ((y_l < W_Y'(S_MIN)) ? S'(S_MIN) : y_l[S-1:0]);
        o_r    = (y_r > W_Y'(S_MAX)) ? S'(S_MAX) :
                 ((y_r < W_Y'(S_MIN)) ? S'(S_MIN) : y_r[S-1:0]);
        o_clip = r_c9 | (y_l > W_Y'(S_MAX)) | (y_l < W_Y'(S_MIN))
                      | (y_r > W_Y'(S_MAX)) | (y_r < W_Y'(S_MIN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (i_en) begin
            r_v8 <= i_valid;
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x8_l <= c_l;
            r_x8_r <= c_r;
            r_sq_l <= n_sq_l;
            r_sq_r <= n_sq_r;
            r_c8   <= clip8;
            r_x9_l <= r_x8_l;
            r_x9_r <= r_x8_r;
            r_t_l  <= n_t_l;
            r_t_r  <= n_t_r;
            r_c9   <= r_c8;
        end
    end

    assign o_valid = r_v9;

endmodule

// File: rtl/swb_out.sv
// swb_out: output register plus skid register; its free slot gates the
// whole pipeline so the upstream stall is a registered signal. Depends on swb_pkg.
module swb_out (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic signed [swb_pkg::SAMPLE_BITS-1:0] i_l,
    input  logic signed [swb_pkg::SAMPLE_BITS-1:0] i_r,
    input  logic                                   i_clip,
    input  logic                                   i_tready,
    output logic                                   o_tvalid,
    output logic signed [swb_pkg::SAMPLE_BITS-1:0] o_l,
    output logic signed [swb_pkg::SAMPLE_BITS-1:0] o_r,
    output logic                                   o_clip,
    output logic                                   o_room
);
    import swb_pkg::*;

    logic                          r_o_valid, n_o_valid;
    logic                          r_sk_valid, n_sk_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_l, r_o_r, r_sk_l, r_sk_r;
    logic signed [SAMPLE_BITS-1:0] n_o_l, n_o_r, n_sk_l, n_sk_r;
    logic                          r_o_clip, r_sk_clip, n_o_clip, n_sk_clip;
    logic                          out_free;

    assign out_free = !r_o_valid || i_tready;

    always_comb begin
        n_o_valid  = r_o_valid;
        n_sk_valid = r_sk_valid;
        n_o_l      = r_o_l;
        n_o_r      = r_o_r;
        n_o_clip   = r_o_clip;
        n_sk_l     = r_sk_l;
        n_sk_r     = r_sk_r;
        n_sk_clip  = r_sk_clip;
        if (out_free) begin
            if (r_sk_valid) begin
                n_o_valid  = 1'b1;
                n_sk_valid = 1'b0;
                n_o_l      = r_sk_l;
                n_o_r      = r_sk_r;
                n_o_clip   = r_sk_clip;
            end else begin
                n_o_valid = i_push;
                n_o_l     = i_l;
                n_o_r     = i_r;
                n_o_clip  = i_clip;
            end
        end else if (i_push) begin
            n_sk_valid = 1'b1;
            n_sk_l     = i_l;
            n_sk_r     = i_r;
            n_sk_clip  = i_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            r_o_valid  <= n_o_valid;
            r_sk_valid <= n_sk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_l     <= n_o_l;
        r_o_r     <= n_o_r;
        r_o_clip  <= n_o_clip;
        r_sk_l    <= n_sk_l;
        r_sk_r    <= n_sk_r;
        r_sk_clip <= n_sk_clip;
    end

    assign o_tvalid = r_o_valid;
    assign o_l      = r_o_l;
    assign o_r      = r_o_r;
    assign o_clip   = r_o_clip;
    assign o_room   = !r_sk_valid;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid holds an item while output register is empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_sk_valid)
        else $error("pipeline pushed into a full skid register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !i_tready) |=> (r_sk_valid && $stable(r_sk_l) && $stable(r_sk_r)))
        else $error("skid item lost during stall");
`endif

endmodule

// File: rtl/stereo_width_balance_crossfeed_exciter.sv
// Stereo width / balance / crossfeed / exciter, one stereo frame per item.
// Path: from input accept to o_tvalid through 9 stage registers (at most
// one multiplier per channel per stage), then the output register.
// Throughput: one item per cycle; a 2-entry output register/skid pair stalls
// the pipeline only when the downstream side holds off.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
module stereo_width_balance_crossfeed_exciter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [swb_pkg::DATA_BITS-1:0]          s_axis_tdata,  // left_in, right_in
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [swb_pkg::DATA_BITS-1:0]          m_axis_tdata,  // left_out, right_out
    output logic [0:0]                             m_axis_tuser,  // clipped
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [swb_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [swb_pkg::APB_BITS-1:0]           pwdata,
    output logic [swb_pkg::APB_BITS-1:0]           prdata,
    output logic                                   pready
);
    import swb_pkg::*;

    t_cfg                   cfg;
    logic                   en;
    logic                   g_valid, i_valid7, x_valid;
    logic signed [W_G2-1:0] g_l, g_r;
    logic signed [W_L6-1:0] im_l, im_r;
    logic signed [SAMPLE_BITS-1:0] x_l, x_r, o_l, o_r;
    logic                   x_clip, o_clip;

    assign pready = 1'b1;

    swb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    swb_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_l     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_r     (s_axis_tdata[DATA_BITS-1:SAMPLE_BITS]),
        .i_cfg   (cfg),
        .o_valid (g_valid),
        .o_l     (g_l),
        .o_r     (g_r)
    );

    swb_image u_image (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_l     (g_l),
        .i_r     (g_r),
        .i_cfg   (cfg),
        .o_valid (i_valid7),
        .o_l     (im_l),
        .o_r     (im_r)
    );

    swb_exciter u_exciter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid7),
        .i_l     (im_l),
        .i_r     (im_r),
        .i_cfg   (cfg),
        .o_valid (x_valid),
        .o_l     (x_l),
        .o_r     (x_r),
        .o_clip  (x_clip)
    );

    swb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (x_valid & en),
        .i_l      (x_l),
        .i_r      (x_r),
        .i_clip   (x_clip),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_l      (o_l),
        .o_r      (o_r),
        .o_clip   (o_clip),
        .o_room   (en)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = {o_r, o_l};
    assign m_axis_tuser  = o_clip;

endmodule
